[hdl/fmbp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the FLAC metadata block parser.
// No dependencies; imported by fmbp_parser and the top level.
package fmbp_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_INFO   = 3'd1,
    PH_SEEK   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_HALT   = 3'd4
  } phase_t;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_HEADER       = 3'd0,
    KIND_INFO_OK      = 3'd1,
    KIND_SEEK_OK      = 3'd2,
    KIND_FORBIDDEN    = 3'd3,
    KIND_INFO_BAD     = 3'd4,
    KIND_SEEK_LEN_BAD = 3'd5,
    KIND_SEEK_ORDER   = 3'd6
  } kind_t;

  localparam logic [6:0]  TYPE_STREAMINFO    = 7'd0;
  localparam logic [6:0]  TYPE_SEEKTABLE     = 7'd3;
  localparam logic [6:0]  TYPE_FORBIDDEN     = 7'd127;
  localparam logic [23:0] INFO_LENGTH        = 24'd34;
  localparam logic [23:0] INFO_CAPTURE_BYTES = 24'd18;
  localparam logic [4:0]  SEEK_POINT_BYTES   = 5'd18;
  localparam logic [4:0]  SEEK_SAMPLE_BYTES  = 5'd8;
  localparam logic [15:0] MIN_BLK_SAMPLES    = 16'd16;
  localparam logic [5:0]  MIN_BPS            = 6'd4;
  localparam logic [1:0]  HEADER_LAST_BYTE   = 2'd3;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [6:0]  hdr_type;
    logic        is_last_block;
    logic [23:0] hdr_length;
    logic [15:0] min_blk_samples;
    logic [15:0] max_blk_samples;
    logic [23:0] min_frm_bytes;
    logic [23:0] max_frm_bytes;
    logic [19:0] sample_rate;
    logic [3:0]  channels;
    logic [5:0]  sample_bits;
    logic [35:0] total_samples;
  } fmbp_result_t;

  // x mod 18 for x < 512: reciprocal estimate (x*56 >> 10) is low by at most
  // one, so a single compare and subtract finishes it.
  function automatic logic [4:0] mod18(input logic [8:0] x);
    logic [14:0] prod;
    logic [4:0]  q;
    logic [8:0]  r;
    prod = 15'(x) * 15'd56;
    q    = prod[14:10];
    r    = x - 9'(q) * 9'(SEEK_POINT_BYTES);
    if (r >= 9'(SEEK_POINT_BYTES)) begin
      r = r - 9'(SEEK_POINT_BYTES);
    end
    return r[4:0];
  endfunction

endpackage

[hdl/fmbp_parser.sv]
`timescale 1ns / 1ps
// Byte-at-a-time metadata parser state and next-state logic.
// Depends on fmbp_pkg.
module fmbp_parser
  import fmbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step_en,
  input  logic [7:0]   data_byte,
  input  logic         restart,
  output logic         res_valid,
  output fmbp_result_t res
);

  phase_t        phase, phase_next;
  logic [23:0]   byte_cnt, byte_cnt_next;
  logic [23:0]   header_shift, header_shift_next;
  logic [4:0]    len_mod, len_mod_next;
  logic [6:0]    cur_type, cur_type_next;
  logic          cur_last, cur_last_next;
  logic [23:0]   cur_length, cur_length_next;
  logic [143:0]  info_shift, info_shift_next;
  logic [4:0]    point_byte_index, point_byte_index_next;
  logic [63:0]   point_sample, point_sample_next;
  logic [63:0]   prev_sample, prev_sample_next;

  logic          emit;
  kind_t         emit_kind;
  logic          emit_info;
  logic          info_ok;

  // STREAMINFO checks on the captured leading 18 bytes
  always_comb begin
    info_ok = (info_shift[143:128] >= MIN_BLK_SAMPLES) &&
              (info_shift[127:112] >= MIN_BLK_SAMPLES) &&
              (info_shift[143:128] <= info_shift[127:112]) &&
              (info_shift[63:44] != 20'd0) &&
              ((6'(info_shift[40:36]) + 6'd1) >= MIN_BPS);
  end

  // Next state
  always_comb begin
    phase_t      ph;
    logic [23:0] bc;
    logic [23:0] bc_inc;
    logic [23:0] new_len;
    logic [4:0]  mod_step;
    logic [4:0]  idx_inc;
    logic [63:0] ps_new;

    ph       = restart ? PH_HEADER : phase;
    bc       = restart ? 24'd0 : byte_cnt;
    bc_inc   = bc + 24'd1;
    new_len  = {header_shift[15:0], data_byte};
    mod_step = mod18(9'({len_mod, 2'b00}) + 9'(data_byte));
    idx_inc  = point_byte_index + 5'd1;
    ps_new   = (point_byte_index < SEEK_SAMPLE_BYTES) ?
               {point_sample[55:0], data_byte} : point_sample;

    phase_next            = ph;
    byte_cnt_next         = bc;
    header_shift_next     = restart ? 24'd0 : header_shift;
    len_mod_next          = len_mod;
    cur_type_next         = cur_type;
    cur_last_next         = cur_last;
    cur_length_next       = cur_length;
    info_shift_next       = info_shift;
    point_byte_index_next = point_byte_index;
    point_sample_next     = point_sample;
    prev_sample_next      = prev_sample;
    emit                  = 1'b0;
    emit_kind             = KIND_HEADER;
    emit_info             = 1'b0;

    unique case (ph)
      PH_HEADER: begin
        if (bc[1:0] != HEADER_LAST_BYTE) begin
          header_shift_next = {header_shift_next[15:0], data_byte};
          byte_cnt_next     = bc_inc;
          // length residue mod 18 over the two upper length bytes
          len_mod_next      = (bc == 24'd0) ? 5'd0 : mod_step;
        end else begin
          cur_last_next         = header_shift[23];
          cur_type_next         = header_shift[22:16];
          cur_length_next       = new_len;
          byte_cnt_next         = 24'd0;
          header_shift_next     = 24'd0;
          info_shift_next       = '0;
          point_byte_index_next = 5'd0;
          point_sample_next     = 64'd0;
          prev_sample_next      = 64'd0;
          emit                  = 1'b1;
          if (header_shift[22:16] == TYPE_FORBIDDEN) begin
            phase_next = PH_HALT;
            emit_kind  = KIND_FORBIDDEN;
          end else if (header_shift[22:16] == TYPE_STREAMINFO) begin
            if (new_len != INFO_LENGTH) begin
              phase_next = PH_HALT;
              emit_kind  = KIND_INFO_BAD;
            end else begin
              phase_next = PH_INFO;
            end
          end else if (header_shift[22:16] == TYPE_SEEKTABLE) begin
            if (mod_step != 5'd0) begin
              phase_next = PH_HALT;
              emit_kind  = KIND_SEEK_LEN_BAD;
            end else if (new_len == 24'd0) begin
              phase_next = header_shift[23] ? PH_HALT : PH_HEADER;
              emit_kind  = KIND_SEEK_OK;
            end else begin
              phase_next = PH_SEEK;
            end
          end else begin
            if (new_len == 24'd0) begin
              phase_next = header_shift[23] ? PH_HALT : PH_HEADER;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_INFO: begin
        if (bc < INFO_CAPTURE_BYTES) begin
          info_shift_next = {info_shift[135:0], data_byte};
        end
        byte_cnt_next = bc_inc;
        if (bc_inc >= INFO_LENGTH) begin
          emit      = 1'b1;
          emit_info = 1'b1;
          if (info_ok) begin
            emit_kind         = KIND_INFO_OK;
            phase_next        = cur_last ? PH_HALT : PH_HEADER;
            byte_cnt_next     = 24'd0;
            header_shift_next = 24'd0;
          end else begin
            emit_kind  = KIND_INFO_BAD;
            phase_next = PH_HALT;
          end
        end
      end
      PH_SEEK: begin
        point_sample_next     = ps_new;
        point_byte_index_next = idx_inc;
        if ((idx_inc == SEEK_SAMPLE_BYTES) && (ps_new != '1) &&
            (ps_new < prev_sample)) begin
          phase_next = PH_HALT;
          emit       = 1'b1;
          emit_kind  = KIND_SEEK_ORDER;
        end else begin
          if ((idx_inc == SEEK_SAMPLE_BYTES) && (ps_new != '1)) begin
            prev_sample_next = ps_new;
          end
          if (idx_inc >= SEEK_POINT_BYTES) begin
            point_byte_index_next = 5'd0;
            point_sample_next     = 64'd0;
          end
          byte_cnt_next = bc_inc;
          if (bc_inc == cur_length) begin
            phase_next        = cur_last ? PH_HALT : PH_HEADER;
            byte_cnt_next     = 24'd0;
            header_shift_next = 24'd0;
            emit              = 1'b1;
            emit_kind         = KIND_SEEK_OK;
          end
        end
      end
      PH_SKIP: begin
        byte_cnt_next = bc_inc;
        if (bc_inc == cur_length) begin
          phase_next        = cur_last ? PH_HALT : PH_HEADER;
          byte_cnt_next     = 24'd0;
          header_shift_next = 24'd0;
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res_valid          = step_en && emit;
    res                = '0;
    res.kind           = emit_kind;
    res.hdr_type       = cur_type_next;
    res.is_last_block  = cur_last_next;
    res.hdr_length     = cur_length_next;
    if (emit_info) begin
      res.min_blk_samples = info_shift[143:128];
      res.max_blk_samples = info_shift[127:112];
      res.min_frm_bytes   = info_shift[111:88];
      res.max_frm_bytes   = info_shift[87:64];
      res.sample_rate     = info_shift[63:44];
      res.channels        = 4'(info_shift[43:41]) + 4'd1;
      res.sample_bits     = 6'(info_shift[40:36]) + 6'd1;
      res.total_samples   = info_shift[35:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_cnt         <= 24'd0;
      header_shift     <= 24'd0;
      len_mod          <= 5'd0;
      cur_type         <= 7'd0;
      cur_last         <= 1'b0;
      cur_length       <= 24'd0;
      info_shift       <= '0;
      point_byte_index <= 5'd0;
      point_sample     <= 64'd0;
      prev_sample      <= 64'd0;
    end else if (step_en) begin
      phase            <= phase_next;
      byte_cnt         <= byte_cnt_next;
      header_shift     <= header_shift_next;
      len_mod          <= len_mod_next;
      cur_type         <= cur_type_next;
      cur_last         <= cur_last_next;
      cur_length       <= cur_length_next;
      info_shift       <= info_shift_next;
      point_byte_index <= point_byte_index_next;
      point_sample     <= point_sample_next;
      prev_sample      <= prev_sample_next;
    end
  end

endmodule

[hdl/flac_metadata_block_parser_unit.sv]
`timescale 1ns / 1ps
// FLAC metadata block parser: one byte transfer in, at most one result out.
// Timing: a result caused by a byte is registered and presented in the cycle after its transfer.
// Throughput: one byte per cycle; the single output register holds input off
//   only while a result waits on a stalled consumer.
// Reset: synchronous active-high rst returns to the header phase and empties
//   the output register; a byte with restart set restarts parsing in-band.
module flac_metadata_block_parser_unit
  import fmbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,   // [0] restart
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [6:0] hdr_type, [7] is_last_block, [31:8] hdr_length,
  // [47:32] min_blk_samples, [63:48] max_blk_samples, [87:64] min_frm_bytes,
  // [111:88] max_frm_bytes, [131:112] sample_rate, [135:132] channels,
  // [141:136] sample_bits, [177:142] total_samples, [183:178] zero
  output logic [183:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser    // [2:0] kind
);

  logic         in_xfer;
  logic         res_valid;
  fmbp_result_t res;
  fmbp_result_t out_res;

  // Take a byte whenever the output register is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  fmbp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step_en   (in_xfer),
    .data_byte (s_axis_tdata),
    .restart   (s_axis_tuser[0]),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: load on a result, drop on a completed transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Payload holds until replaced; no reset needed
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {6'd0,
                         out_res.total_samples,
                         out_res.sample_bits,
                         out_res.channels,
                         out_res.sample_rate,
                         out_res.max_frm_bytes,
                         out_res.min_frm_bytes,
                         out_res.max_blk_samples,
                         out_res.min_blk_samples,
                         out_res.hdr_length,
                         out_res.is_last_block,
                         out_res.hdr_type};

  // Input is held off only while a result waits on a stalled consumer
  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // A result is never produced by a cycle that took no byte
  a_result_needs_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_xfer)
    else $error("result without an input transfer");

  // STREAMINFO fields are zero except for the two STREAMINFO verdicts
  a_info_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != KIND_INFO_OK) && (m_axis_tuser != KIND_INFO_BAD))
    |-> (m_axis_tdata[177:32] == '0))
    else $error("streaminfo fields nonzero on a non-streaminfo result");

  // A waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("pending result overwritten");

endmodule
